>>> rtl/mfda_pkg.sv
// Shared constants, codes and types for the mesh face deviation accumulator.
package mfda_pkg;

  localparam int CW             = 32;  // coordinate and area width
  localparam int MAX_LEVELS_DEF = 8;
  localparam int CFG_AW         = 2;

  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam logic [CFG_AW-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_LEVELS    = 2'd1;

  // ceil(2^35 / 3): exact floor(x / 3) for x below 2^34
  localparam logic [33:0] RECIP3 = 34'd11453246123;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SPLIT,
    ST_CENT,
    ST_SQ,
    ST_ADD,
    ST_SQRT,
    ST_W0,
    ST_W1,
    ST_W2,
    ST_W3,
    ST_DIV,
    ST_DNEXT,
    ST_RSQRT,
    ST_FIN
  } state_t;

endpackage

>>> rtl/mfda_if.sv
// Handshake channels: input items, result items and configuration writes.
interface mfda_src_if import mfda_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic signed [CW-1:0] a_x;
  logic signed [CW-1:0] a_y;
  logic signed [CW-1:0] a_z;
  logic signed [CW-1:0] b_x;
  logic signed [CW-1:0] b_y;
  logic signed [CW-1:0] b_z;
  logic        [CW-1:0] face_area;
  modport source (output valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, face_area,
                  input ready);
  modport sink (input valid, kind, a_x, a_y, a_z, b_x, b_y, b_z, face_area,
                output ready);
endinterface

interface mfda_res_if import mfda_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [CW-1:0] mean_distance;
  logic [CW-1:0] rms_distance;
  logic [16:0]   deviation_fraction;
  logic [CW-1:0] max_distance;
  logic          empty_set;
  modport source (output valid, mean_distance, rms_distance, deviation_fraction,
                  max_distance, empty_set, input ready);
  modport sink (input valid, mean_distance, rms_distance, deviation_fraction,
                max_distance, empty_set, output ready);
endinterface

interface mfda_cfg_if import mfda_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] addr;
  logic [CW-1:0]     data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

>>> rtl/mesh_face_deviation_accumulator.sv
// Top level: face subdivision, leaf distance and area-weighted statistics.
//
//   channel  dir  beat
//   src      in   one vertex pair (kind 0) or a finish request (kind 1)
//   res      out  mean, rms, deviation fraction, max, empty flag per finish
//   cfg      in   register write: addr 0 threshold, addr 1 subdivision levels
//
// A first or second vertex is only stored. A third vertex runs 2^levels leaves
// through one sqrt/multiply/divide datapath: per leaf a load, a split step per
// level, centroid/square/add per axis, the 32-step square root and W0-W3. A
// finish runs three divisions and 32 root steps, or none for an empty set.
// Reset is synchronous and needs no clearing pass. A pending result does not
// block vertex beats; a finish waits until the result register is free.
module mesh_face_deviation_accumulator
  import mfda_pkg::*;
#(
  parameter int MAX_LEVELS = MAX_LEVELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mfda_src_if.sink    src,
  mfda_res_if.source  res,
  mfda_cfg_if.sink    cfg
);

  localparam int LW  = (MAX_LEVELS < 1) ? 1 : $clog2(MAX_LEVELS + 1);
  localparam int LFW = MAX_LEVELS + 1;
  localparam logic [63:0] SAT64 = {64{1'b1}};

  function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? SAT64 : s[63:0];
  endfunction

  function automatic logic signed [CW-1:0] mid(input logic signed [CW-1:0] p,
                                               input logic signed [CW-1:0] q);
    logic signed [CW:0] s;
    s = {p[CW-1], p} + {q[CW-1], q};
    s = s + {{CW{1'b0}}, s[CW]};   // round toward zero
    return s[CW:1];
  endfunction

  function automatic logic signed [CW:0] div3(input logic signed [CW+1:0] s);
    logic [CW+1:0] mag;
    logic [68:0]   p;
    logic [CW:0]   q;
    mag = s[CW+1] ? -s : s;
    p   = {35'd0, mag} * {35'd0, RECIP3};
    q   = {1'b0, p[66:35]};
    return s[CW+1] ? -q : q;
  endfunction

  state_t state, state_next;

  logic [CW-1:0] threshold;
  logic [3:0]    levels_cfg;
  logic [LW-1:0] lev;

  logic signed [CW-1:0] sa [3][3];
  logic signed [CW-1:0] sb [3][3];
  logic signed [CW-1:0] wa [3][3];
  logic signed [CW-1:0] wb [3][3];
  logic [1:0]    vcount;
  logic [CW-1:0] face_area;

  logic [LFW-1:0] leaf;
  logic [LFW-1:0] leaf_end;
  logic [LW-1:0]  step;
  logic [LFW-1:0] leaf_shift;
  logic [1:0]     ax;
  logic [CW:0]    mag;
  logic [63:0]    sq;
  logic [63:0]    sq_next;
  logic [63:0]    p0;
  logic [CW-1:0]  leaf_area;

  logic [CW-1:0] mul_x, mul_y;
  logic [63:0]   prod;
  logic [63:0]   wsq;

  logic [63:0] sum_wd, sum_wsq, sum_dev, sum_area;
  logic [CW-1:0] largest;

  logic [63:0] rt_n, rt_res, rt_bit, rt_t;
  logic [4:0]  rt_cnt;

  logic [79:0] dvd, quo;
  logic [64:0] rem, rem_sh;
  logic [6:0]  dcnt;
  logic [1:0]  dsel;
  logic [CW-1:0] mean_q;
  logic [63:0]   msq_q;
  logic [16:0]   frac_q;

  logic signed [CW+1:0] csum_a, csum_b;
  logic signed [CW+1:0] cdiff;

  logic in_acc, out_valid;

  assign cfg.ready = 1'b1;
  assign src.ready = (state == ST_IDLE) && (!out_valid || src.kind == KIND_VERTEX);
  assign in_acc    = src.valid && src.ready;
  assign res.valid = out_valid;

  assign lev = ({1'b0, levels_cfg} > 5'(MAX_LEVELS)) ? LW'(MAX_LEVELS) : LW'(levels_cfg);
  assign leaf_end   = (LFW'(1) << lev) - LFW'(1);
  assign leaf_shift = leaf >> (lev - LW'(1) - step);
  assign leaf_area  = face_area >> lev;

  assign csum_a = (CW+2)'(wa[0][ax]) + (CW+2)'(wa[1][ax]) + (CW+2)'(wa[2][ax]);
  assign csum_b = (CW+2)'(wb[0][ax]) + (CW+2)'(wb[1][ax]) + (CW+2)'(wb[2][ax]);
  assign cdiff  = (CW+2)'(div3(csum_a)) - (CW+2)'(div3(csum_b));

  assign sq_next = add_sat(sq, mag[CW] ? SAT64 : prod);
  assign wsq = (|prod[63:48]) ? SAT64 : add_sat({prod[47:0], 16'd0}, {16'd0, p0[63:16]});
  assign rt_t   = rt_res + rt_bit;
  assign rem_sh = {rem[63:0], dvd[79]};

  // shared multiplier operand select
  always_comb begin
    mul_x = mag[CW-1:0];
    mul_y = mag[CW-1:0];
    case (state)
      ST_W0: begin
        mul_x = leaf_area;
        mul_y = rt_res[CW-1:0];
      end
      ST_W1: begin
        mul_x = leaf_area;
        mul_y = sq[31:0];
      end
      ST_W2: begin
        mul_x = leaf_area;
        mul_y = sq[63:32];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (src.kind == KIND_FINISH) begin
            state_next = (sum_area == 64'd0) ? ST_IDLE : ST_DIV;
          end else if (vcount == 2'd2) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_LOAD:  state_next = (lev == LW'(0)) ? ST_CENT : ST_SPLIT;
      ST_SPLIT: state_next = (step == lev - LW'(1)) ? ST_CENT : ST_SPLIT;
      ST_CENT:  state_next = ST_SQ;
      ST_SQ:    state_next = ST_ADD;
      ST_ADD:   state_next = (ax == 2'd2) ? ST_SQRT : ST_CENT;
      ST_SQRT:  state_next = (rt_cnt == 5'd31) ? ST_W0 : ST_SQRT;
      ST_W0:    state_next = ST_W1;
      ST_W1:    state_next = ST_W2;
      ST_W2:    state_next = ST_W3;
      ST_W3:    state_next = (leaf == leaf_end) ? ST_IDLE : ST_LOAD;
      ST_DIV:   state_next = (dcnt == 7'd79) ? ST_DNEXT : ST_DIV;
      ST_DNEXT: state_next = (dsel == 2'd2) ? ST_RSQRT : ST_DIV;
      ST_RSQRT: state_next = (rt_cnt == 5'd31) ? ST_FIN : ST_RSQRT;
      ST_FIN:   state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;

    if (in_acc && src.kind == KIND_VERTEX) begin
      sa[vcount == 2'd3 ? 2'd0 : vcount][0] <= src.a_x;
      sa[vcount == 2'd3 ? 2'd0 : vcount][1] <= src.a_y;
      sa[vcount == 2'd3 ? 2'd0 : vcount][2] <= src.a_z;
      sb[vcount == 2'd3 ? 2'd0 : vcount][0] <= src.b_x;
      sb[vcount == 2'd3 ? 2'd0 : vcount][1] <= src.b_y;
      sb[vcount == 2'd3 ? 2'd0 : vcount][2] <= src.b_z;
      face_area <= src.face_area;
    end

    case (state)
      ST_LOAD: begin
        wa   <= sa;
        wb   <= sb;
        step <= '0;
        ax   <= '0;
        sq   <= '0;
      end
      ST_SPLIT: begin
        // child: (mid of 1-2, old 0, old 1 or old 2)
        for (int k = 0; k < 3; k++) begin
          wa[0][k] <= mid(wa[1][k], wa[2][k]);
          wb[0][k] <= mid(wb[1][k], wb[2][k]);
          wa[1][k] <= wa[0][k];
          wb[1][k] <= wb[0][k];
          wa[2][k] <= leaf_shift[0] ? wa[2][k] : wa[1][k];
          wb[2][k] <= leaf_shift[0] ? wb[2][k] : wb[1][k];
        end
        step <= step + LW'(1);
      end
      ST_CENT: mag <= cdiff[CW+1] ? (CW+1)'(-cdiff) : cdiff[CW:0];
      ST_ADD: begin
        sq     <= sq_next;
        ax     <= ax + 2'd1;
        rt_n   <= sq_next;
        rt_res <= '0;
        rt_bit <= 64'd1 << 62;
        rt_cnt <= '0;
      end
      ST_SQRT, ST_RSQRT: begin
        if (rt_n >= rt_t) begin
          rt_n   <= rt_n - rt_t;
          rt_res <= (rt_res >> 1) + rt_bit;
        end else begin
          rt_res <= rt_res >> 1;
        end
        rt_bit <= rt_bit >> 2;
        rt_cnt <= rt_cnt + 5'd1;
      end
      ST_W2: p0 <= prod;
      ST_W3: leaf <= leaf + LFW'(1);
      ST_DIV: begin
        if (rem_sh >= {1'b0, sum_area}) begin
          rem <= rem_sh - {1'b0, sum_area};
          quo <= {quo[78:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[78:0], 1'b0};
        end
        dvd  <= dvd << 1;
        dcnt <= dcnt + 7'd1;
      end
      ST_DNEXT: begin
        case (dsel)
          2'd0: mean_q <= (|quo[79:48]) ? {CW{1'b1}} : quo[47:16];
          2'd1: msq_q  <= (|quo[79:64]) ? SAT64 : quo[63:0];
          default: frac_q <= (quo > 80'd65536) ? 17'd65536 : quo[16:0];
        endcase
        dsel <= dsel + 2'd1;
        dvd  <= {(dsel == 2'd0) ? sum_wsq : sum_dev, 16'd0};
        rem  <= '0;
        dcnt <= '0;
        rt_n   <= msq_q;
        rt_res <= '0;
        rt_bit <= 64'd1 << 62;
        rt_cnt <= '0;
      end
      default: ;
    endcase

    if (in_acc && src.kind == KIND_VERTEX && vcount == 2'd2) begin
      leaf <= '0;
    end
    if (in_acc && src.kind == KIND_FINISH) begin
      dvd  <= {sum_wd, 16'd0};
      rem  <= '0;
      dcnt <= '0;
      dsel <= '0;
    end

    if (rst) begin
      threshold  <= '0;
      levels_cfg <= '0;
    end else if (cfg.valid) begin
      if (cfg.addr == CFG_THRESHOLD) begin
        threshold <= cfg.data;
      end else if (cfg.addr == CFG_LEVELS) begin
        levels_cfg <= cfg.data[3:0];
      end
    end
  end

  // accumulators, vertex count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      vcount    <= '0;
      sum_wd    <= '0;
      sum_wsq   <= '0;
      sum_dev   <= '0;
      sum_area  <= '0;
      largest   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && res.ready) begin
        out_valid <= 1'b0;
      end
      if (in_acc) begin
        if (src.kind == KIND_VERTEX) begin
          vcount <= (vcount >= 2'd2) ? 2'd0 : vcount + 2'd1;
        end else begin
          vcount <= '0;
          if (sum_area == 64'd0) begin
            res.mean_distance      <= '0;
            res.rms_distance       <= '0;
            res.deviation_fraction <= '0;
            res.max_distance       <= '0;
            res.empty_set          <= 1'b1;
            out_valid              <= 1'b1;
            // zero-area leaves may still have raised the max
            largest                <= '0;
          end
        end
      end
      case (state)
        ST_W1: sum_wd <= add_sat(sum_wd, prod);
        ST_W3: begin
          sum_wsq  <= add_sat(sum_wsq, wsq);
          sum_area <= add_sat(sum_area, {32'd0, leaf_area});
          if (rt_res[CW-1:0] > threshold) begin
            sum_dev <= add_sat(sum_dev, {32'd0, leaf_area});
          end
          if (rt_res[CW-1:0] > largest) begin
            largest <= rt_res[CW-1:0];
          end
        end
        ST_FIN: begin
          res.mean_distance      <= mean_q;
          res.rms_distance       <= rt_res[CW-1:0];
          res.deviation_fraction <= frac_q;
          res.max_distance       <= largest;
          res.empty_set          <= 1'b0;
          out_valid              <= 1'b1;
          sum_wd   <= '0;
          sum_wsq  <= '0;
          sum_dev  <= '0;
          sum_area <= '0;
          largest  <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule
